>>> design/lpcd_pkg.sv
// Shared constants, codes and types of the page cache directory.
package lpcd_pkg;

   localparam int unsigned NUM_SLOTS = 512;
   localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
   localparam int unsigned COUNT_W   = SLOT_W + 1;
   localparam int unsigned CAP_W     = 10;
   localparam int unsigned PAGE_W    = 32;
   localparam int unsigned CSR_W     = 10;

   // request kinds
   localparam logic [2:0] KIND_ACQUIRE = 3'd0;
   localparam logic [2:0] KIND_RELEASE = 3'd1;
   localparam logic [2:0] KIND_CREATE  = 3'd2;
   localparam logic [2:0] KIND_DELETE  = 3'd3;
   localparam logic [2:0] KIND_FLUSH   = 3'd4;

   // response status
   localparam logic [2:0] ST_HIT     = 3'd0;
   localparam logic [2:0] ST_FREE    = 3'd1;
   localparam logic [2:0] ST_EVICT   = 3'd2;
   localparam logic [2:0] ST_ABSENT  = 3'd3;
   localparam logic [2:0] ST_PINNED  = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;
   localparam logic [2:0] ST_PRESENT = 3'd6;

   // register indexes
   localparam logic CSR_CAPACITY      = 1'b0;
   localparam logic CSR_WRITEBACK_ALL = 1'b1;

   typedef struct packed {
      logic              valid;
      logic              pinned;
      logic              dirty;
      logic [PAGE_W-1:0] page;
   } slot_ent_type;

endpackage

>>> design/lru_page_cache_directory.sv
// Top level: LRU page buffer pool directory with pinning and dirty marks.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  req     | in        | req_valid/req_ready  | req_kind, req_page_id, req_modified
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_status, rsp_slot, rsp_load_needed,
//          |           |                      | rsp_writeback, rsp_writeback_page
//  csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// One transaction at a time. The tag search streams the slot table through one
// compare unit, one slot per cycle, then, where needed, the recency list is updated.
// An eviction walks the recency list from the oldest slot, reading and then checking
// each visited slot. After reset a clearing pass over all 512 slots empties the slot
// table; req_ready stays low meanwhile. A finished response waits in the output
// register while rsp_ready is low; the next request is taken as soon as the
// sequencer is idle.
module lru_page_cache_directory (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_kind,
   input  logic [lpcd_pkg::PAGE_W-1:0]  req_page_id,
   input  logic                         req_modified,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_status,
   output logic [lpcd_pkg::SLOT_W-1:0]  rsp_slot,
   output logic                         rsp_load_needed,
   output logic                         rsp_writeback,
   output logic [lpcd_pkg::PAGE_W-1:0]  rsp_writeback_page,
   input  logic                         csr_wr_en,
   input  logic                         csr_index,
   input  logic [lpcd_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int unsigned SW = lpcd_pkg::SLOT_W;
   localparam int unsigned CW = lpcd_pkg::COUNT_W;
   localparam int unsigned PW = lpcd_pkg::PAGE_W;
   localparam int unsigned EW = $bits(lpcd_pkg::slot_ent_type);
   localparam logic [CW-1:0] NSLOTS = CW'(lpcd_pkg::NUM_SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(lpcd_pkg::NUM_SLOTS - 1);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_SCAN    = 4'd2;
   localparam logic [3:0] S_DECIDE  = 4'd3;
   localparam logic [3:0] S_WALK_RD = 4'd4;
   localparam logic [3:0] S_WALK_CK = 4'd5;
   localparam logic [3:0] S_MKNEW   = 4'd6;
   localparam logic [3:0] S_LINK_RD = 4'd7;
   localparam logic [3:0] S_UNLINK  = 4'd8;
   localparam logic [3:0] S_PUSH1   = 4'd9;
   localparam logic [3:0] S_PUSH2   = 4'd10;
   localparam logic [3:0] S_FINISH  = 4'd11;

   // control state
   logic [3:0]      state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;           // clear sweep, scan issue, walk steps
   logic            pend_ff, pend_in;
   logic [SW-1:0]   pend_addr_ff, pend_addr_in;
   logic            hit_ff, hit_in;
   logic            free_ok_ff, free_ok_in;
   logic [SW-1:0]   newest_ff, newest_in;
   logic [SW-1:0]   oldest_ff, oldest_in;
   logic [CW-1:0]   used_ff, used_in;
   logic [CW-1:0]   cap_ff;
   logic            wball_ff;
   logic            rsp_valid_ff, rsp_valid_in;

   // payload and work registers
   logic [2:0]      kind_ff, kind_in;
   logic [PW-1:0]   page_ff, page_in;
   logic            mod_ff, mod_in;
   logic [SW-1:0]   hit_slot_ff, hit_slot_in;
   logic            hit_dirty_ff, hit_dirty_in;
   logic [SW-1:0]   free_slot_ff, free_slot_in;
   logic [SW-1:0]   tgt_ff, tgt_in;
   logic [SW-1:0]   prev_ff, prev_in;
   logic            empty_ff, empty_in;
   logic            del_ff, del_in;
   logic [2:0]      res_status_ff, res_status_in;
   logic [SW-1:0]   res_slot_ff, res_slot_in;
   logic            res_load_ff, res_load_in;
   logic            res_wb_ff, res_wb_in;
   logic [PW-1:0]   res_wbp_ff, res_wbp_in;
   logic [2:0]      rsp_status_ff;
   logic [SW-1:0]   rsp_slot_ff;
   logic            rsp_load_ff;
   logic            rsp_wb_ff;
   logic [PW-1:0]   rsp_wbp_ff;

   // table ports
   logic                      ent_we, nw_we, od_we;
   logic [SW-1:0]             ent_wa, nw_wa, od_wa, ent_ra, nw_ra, od_ra;
   lpcd_pkg::slot_ent_type    ent_wd, ent_rd;
   logic [SW-1:0]             nw_wd, od_wd, nw_rd, od_rd;
   logic [EW-1:0]             ent_rd_raw;

   logic [CW-1:0]   eff_cap;
   logic            load_rsp;
   logic            match;

   lpcd_ram #(.WIDTH(EW), .DEPTH(lpcd_pkg::NUM_SLOTS)) u_ent_ram (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(ent_wd),
      .rd_addr(ent_ra), .rd_data(ent_rd_raw));

   lpcd_ram #(.WIDTH(SW), .DEPTH(lpcd_pkg::NUM_SLOTS)) u_newer_ram (
      .clock(clock), .wr_en(nw_we), .wr_addr(nw_wa), .wr_data(nw_wd),
      .rd_addr(nw_ra), .rd_data(nw_rd));

   lpcd_ram #(.WIDTH(SW), .DEPTH(lpcd_pkg::NUM_SLOTS)) u_older_ram (
      .clock(clock), .wr_en(od_we), .wr_addr(od_wa), .wr_data(od_wd),
      .rd_addr(od_ra), .rd_data(od_rd));

   assign ent_rd = lpcd_pkg::slot_ent_type'(ent_rd_raw);

   // clamp capacity into 1..NUM_SLOTS
   always_comb begin
      eff_cap = cap_ff;
      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (cap_ff > NSLOTS) begin
         eff_cap = NSLOTS;
      end
   end

   assign match = ent_rd.valid && (ent_rd.page == page_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      hit_in        = hit_ff;
      free_ok_in    = free_ok_ff;
      newest_in     = newest_ff;
      oldest_in     = oldest_ff;
      used_in       = used_ff;
      kind_in       = kind_ff;
      page_in       = page_ff;
      mod_in        = mod_ff;
      hit_slot_in   = hit_slot_ff;
      hit_dirty_in  = hit_dirty_ff;
      free_slot_in  = free_slot_ff;
      tgt_in        = tgt_ff;
      prev_in       = prev_ff;
      empty_in      = empty_ff;
      del_in        = del_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_load_in   = res_load_ff;
      res_wb_in     = res_wb_ff;
      res_wbp_in    = res_wbp_ff;
      load_rsp      = 1'b0;
      ent_we = 1'b0; ent_wa = tgt_ff; ent_wd = '0; ent_ra = cnt_ff[SW-1:0];
      nw_we  = 1'b0; nw_wa  = tgt_ff; nw_wd  = '0; nw_ra  = tgt_ff;
      od_we  = 1'b0; od_wa  = tgt_ff; od_wd  = '0; od_ra  = tgt_ff;

      unique case (state_ff)
         S_CLEAR: begin
            ent_we = 1'b1;
            ent_wa = cnt_ff[SW-1:0];
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff[SW-1:0] == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in       = req_kind;
               page_in       = req_page_id;
               mod_in        = req_modified;
               cnt_in        = '0;
               hit_in        = 1'b0;
               free_ok_in    = 1'b0;
               del_in        = 1'b0;
               res_status_in = lpcd_pkg::ST_DONE;
               res_slot_in   = '0;
               res_load_in   = 1'b0;
               res_wb_in     = 1'b0;
               res_wbp_in    = '0;
               state_in      = (req_kind > lpcd_pkg::KIND_FLUSH) ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one read per cycle, check the slot read last cycle
            ent_ra = cnt_ff[SW-1:0];
            if (cnt_ff < NSLOTS) begin
               pend_in      = 1'b1;
               pend_addr_in = cnt_ff[SW-1:0];
               cnt_in       = cnt_ff + CW'(1);
            end
            if (pend_ff) begin
               if (match) begin
                  hit_in       = 1'b1;
                  hit_slot_in  = pend_addr_ff;
                  hit_dirty_in = ent_rd.dirty;
                  state_in     = S_DECIDE;
               end else begin
                  if (!ent_rd.valid && !free_ok_ff) begin
                     free_ok_in   = 1'b1;
                     free_slot_in = pend_addr_ff;
                  end
                  if (pend_addr_ff == LAST_SLOT) begin
                     state_in = S_DECIDE;
                  end
               end
            end
         end
         S_DECIDE: begin
            state_in = S_FINISH;
            ent_wa   = hit_slot_ff;
            if (hit_ff) begin
               res_slot_in = hit_slot_ff;
               unique case (kind_ff)
                  lpcd_pkg::KIND_ACQUIRE: begin
                     ent_we        = 1'b1;
                     ent_wd        = '{valid: 1'b1, pinned: 1'b1, dirty: hit_dirty_ff,
                                       page: page_ff};
                     res_status_in = lpcd_pkg::ST_HIT;
                     tgt_in        = hit_slot_ff;
                     state_in      = S_MKNEW;
                  end
                  lpcd_pkg::KIND_RELEASE: begin
                     ent_we = 1'b1;
                     ent_wd = '{valid: 1'b1, pinned: 1'b0, dirty: hit_dirty_ff | mod_ff,
                                page: page_ff};
                  end
                  lpcd_pkg::KIND_CREATE: begin
                     res_status_in = lpcd_pkg::ST_PRESENT;
                  end
                  lpcd_pkg::KIND_DELETE: begin
                     ent_we   = 1'b1;
                     ent_wd   = '0;
                     used_in  = (used_ff != '0) ? used_ff - CW'(1) : used_ff;
                     del_in   = 1'b1;
                     tgt_in   = hit_slot_ff;
                     state_in = S_LINK_RD;
                  end
                  default: begin
                     // flush: a dirty page takes a read-modify-write pass so the
                     // pin bit survives
                     if (hit_dirty_ff) begin
                        res_wb_in  = 1'b1;
                        res_wbp_in = page_ff;
                        tgt_in     = hit_slot_ff;
                        state_in   = S_WALK_RD;
                     end
                  end
               endcase
            end else begin
               unique case (kind_ff) inside
                  lpcd_pkg::KIND_ACQUIRE, lpcd_pkg::KIND_CREATE: begin
                     if (used_ff < eff_cap && free_ok_ff) begin
                        ent_we        = 1'b1;
                        ent_wa        = free_slot_ff;
                        ent_wd        = '{valid: 1'b1,
                                          pinned: (kind_ff == lpcd_pkg::KIND_ACQUIRE),
                                          dirty: (kind_ff == lpcd_pkg::KIND_CREATE),
                                          page: page_ff};
                        empty_in      = (used_ff == '0);
                        used_in       = used_ff + CW'(1);
                        res_status_in = lpcd_pkg::ST_FREE;
                        res_slot_in   = free_slot_ff;
                        res_load_in   = (kind_ff == lpcd_pkg::KIND_ACQUIRE);
                        tgt_in        = free_slot_ff;
                        state_in      = S_PUSH1;
                     end else if (used_ff == '0) begin
                        res_status_in = lpcd_pkg::ST_PINNED;
                     end else begin
                        tgt_in   = oldest_ff;
                        cnt_in   = '0;
                        state_in = S_WALK_RD;
                     end
                  end
                  lpcd_pkg::KIND_RELEASE, lpcd_pkg::KIND_DELETE: begin
                     res_status_in = lpcd_pkg::ST_ABSENT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK_RD: begin
            ent_ra   = tgt_ff;
            nw_ra    = tgt_ff;
            state_in = S_WALK_CK;
         end
         S_WALK_CK: begin
            ent_wa = tgt_ff;
            if (hit_ff) begin
               // flush of a dirty page: clear dirty, keep the pin
               ent_we   = 1'b1;
               ent_wd   = '{valid: 1'b1, pinned: ent_rd.pinned, dirty: 1'b0, page: page_ff};
               state_in = S_FINISH;
            end else if (ent_rd.valid && !ent_rd.pinned) begin
               if (wball_ff || ent_rd.dirty) begin
                  res_wb_in  = 1'b1;
                  res_wbp_in = ent_rd.page;
               end
               ent_we        = 1'b1;
               ent_wd        = '{valid: 1'b1,
                                 pinned: (kind_ff == lpcd_pkg::KIND_ACQUIRE),
                                 dirty: (kind_ff == lpcd_pkg::KIND_CREATE),
                                 page: page_ff};
               res_status_in = lpcd_pkg::ST_EVICT;
               res_slot_in   = tgt_ff;
               res_load_in   = (kind_ff == lpcd_pkg::KIND_ACQUIRE);
               state_in      = S_MKNEW;
            end else if (cnt_ff + CW'(1) == used_ff) begin
               res_status_in = lpcd_pkg::ST_PINNED;
               state_in      = S_FINISH;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               tgt_in   = nw_rd;
               state_in = S_WALK_RD;
            end
         end
         S_MKNEW: begin
            empty_in = 1'b0;
            state_in = (tgt_ff == newest_ff) ? S_FINISH : S_LINK_RD;
         end
         S_LINK_RD: begin
            nw_ra    = tgt_ff;
            od_ra    = tgt_ff;
            state_in = S_UNLINK;
         end
         S_UNLINK: begin
            if (tgt_ff == newest_ff) begin
               newest_in = od_rd;
            end else begin
               od_we = 1'b1;
               od_wa = nw_rd;
               od_wd = od_rd;
            end
            if (tgt_ff == oldest_ff) begin
               oldest_in = nw_rd;
            end else begin
               nw_we = 1'b1;
               nw_wa = od_rd;
               nw_wd = nw_rd;
            end
            state_in = del_ff ? S_FINISH : S_PUSH1;
         end
         S_PUSH1: begin
            od_we     = 1'b1;
            od_wa     = tgt_ff;
            od_wd     = newest_ff;
            nw_we     = 1'b1;
            nw_wa     = tgt_ff;
            nw_wd     = tgt_ff;
            prev_in   = newest_ff;
            newest_in = tgt_ff;
            if (empty_ff) begin
               oldest_in = tgt_ff;
               state_in  = S_FINISH;
            end else begin
               state_in = S_PUSH2;
            end
         end
         S_PUSH2: begin
            nw_we    = 1'b1;
            nw_wa    = prev_ff;
            nw_wd    = tgt_ff;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         free_ok_ff   <= 1'b0;
         newest_ff    <= '0;
         oldest_ff    <= '0;
         used_ff      <= '0;
         cap_ff       <= NSLOTS;
         wball_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         empty_ff     <= 1'b0;
         del_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         free_ok_ff   <= free_ok_in;
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         empty_ff     <= empty_in;
         del_ff       <= del_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               lpcd_pkg::CSR_CAPACITY:      cap_ff   <= CW'(csr_wdata[lpcd_pkg::CAP_W-1:0]);
               lpcd_pkg::CSR_WRITEBACK_ALL: wball_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff  <= pend_addr_in;
      kind_ff       <= kind_in;
      page_ff       <= page_in;
      mod_ff        <= mod_in;
      hit_slot_ff   <= hit_slot_in;
      hit_dirty_ff  <= hit_dirty_in;
      free_slot_ff  <= free_slot_in;
      tgt_ff        <= tgt_in;
      prev_ff       <= prev_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_load_ff   <= res_load_in;
      res_wb_ff     <= res_wb_in;
      res_wbp_ff    <= res_wbp_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_load_ff   <= res_load_ff;
         rsp_wb_ff     <= res_wb_ff;
         rsp_wbp_ff    <= res_wbp_ff;
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_load_needed    = rsp_load_ff;
   assign rsp_writeback      = rsp_wb_ff;
   assign rsp_writeback_page = rsp_wbp_ff;

   // The directory never counts more slots than it has.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= NSLOTS) else $error("used count above slot count");

   // One request at a time: the sequencer leaves idle right after an accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second request taken");

   // A load request comes only with a fill.
   a_load_on_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_needed |->
      rsp_status == lpcd_pkg::ST_FREE || rsp_status == lpcd_pkg::ST_EVICT)
      else $error("load flagged without fill");

   // An all-pinned answer names slot zero and asks for no writeback.
   a_pinned_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lpcd_pkg::ST_PINNED |-> rsp_slot == '0 && !rsp_writeback)
      else $error("all-pinned response carries data");

endmodule

>>> design/lpcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpcd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
